FILE: hw/rtl/tvm_pkg.sv
// shared constants, types and helpers of the tile vote mask merge block
package tvm_pkg;

    localparam int TILE      = 3;
    localparam int NUM_MASKS = 4;
    localparam int MASK_W    = 8;
    localparam int POS_W     = 13;          // holds a count up to 4096
    localparam int ROW_W     = 12;
    localparam int TROW_W    = 11;
    localparam int TCOL_W    = 9;
    localparam int MAP_W     = TILE * TILE;
    localparam int FLAG_W    = 2 * (TILE - 1);
    localparam int VOTE_W    = 4;
    localparam int CFG_W     = 13;
    localparam int IN_W      = NUM_MASKS * MASK_W;
    localparam int OUT_W     = 32;

    localparam logic [MASK_W-1:0] MID_LEVEL = 8'd128;
    localparam logic [POS_W-1:0]  MAX_ROWS  = 13'd4096;
    localparam logic [2:0]        MASKS_SAT = 3'd4;

    typedef enum logic [1:0] {
        REG_MASKS  = 2'd0,
        REG_COLS   = 2'd1,
        REG_ROWS   = 2'd2,
        REG_THRESH = 2'd3
    } cfg_reg_t;

    // limits in effect, with the position of the last row and column split up
    typedef struct packed {
        logic [2:0]        masks;
        logic [3:0]        thresh;
        logic [POS_W-1:0]  cols;
        logic [POS_W-1:0]  rows;
        logic [POS_W-1:0]  col_last;
        logic [1:0]        dx_last;
        logic [POS_W-1:0]  tcol_last;
        logic [ROW_W-1:0]  row_last;
        logic [1:0]        dy_last;
        logic [TROW_W-1:0] trow_last;
    } cfg_t;

    // one pixel on its way from the position stage to the fuse stage
    typedef struct packed {
        logic              vote;
        logic              dark;
        logic [1:0]        dy;
        logic              tile_end;
        logic              last;
        logic [TROW_W-1:0] trow;
        logic [TCOL_W-1:0] tcol;
    } pix_t;

    // floor(x / 3) for x below 8192, by reciprocal multiply
    function automatic logic [POS_W-1:0] div3(input logic [POS_W-1:0] x);
        logic [24:0] prod;
        prod = 25'(x) * 25'(2731);
        return {1'b0, prod[24:13]};
    endfunction

endpackage

FILE: hw/rtl/tvm_ram.sv
// generic single-port-write, registered-read ram
module tvm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/tvm_cfg.sv
// configuration registers and the limits derived from them
module tvm_cfg #(
    parameter int MAX_COLS = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [tvm_pkg::CFG_W-1:0] cfg_data,
    output tvm_pkg::cfg_t             cfg,
    output logic                      busy
);
    import tvm_pkg::*;

    logic [2:0]       masks_reg;
    logic [10:0]      cols_reg;
    logic [12:0]      rows_reg;
    logic [3:0]       thresh_reg;
    logic             pend_reg;
    cfg_t             lim_reg;
    cfg_t             lim_next;

    logic [POS_W-1:0] cols_e;
    logic [POS_W-1:0] rows_e;
    logic [POS_W-1:0] col_last;
    logic [POS_W-1:0] row_last;
    logic [POS_W-1:0] cq;
    logic [POS_W-1:0] rq;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            masks_reg  <= 3'd3;
            cols_reg   <= 11'd640;
            rows_reg   <= 13'd480;
            thresh_reg <= 4'd6;
            pend_reg   <= 1'b1;
        end
        else
        begin
            pend_reg <= cfg_valid;
            if (cfg_valid)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_MASKS:  masks_reg  <= cfg_data[2:0];
                    REG_COLS:   cols_reg   <= cfg_data[10:0];
                    REG_ROWS:   rows_reg   <= cfg_data[12:0];
                    REG_THRESH: thresh_reg <= cfg_data[3:0];
                    default:    ;
                endcase
            end
        end
    end

    always_comb
    begin
        if ({2'b00, cols_reg} > POS_W'(MAX_COLS))
        begin
            cols_e = POS_W'(MAX_COLS);
        end
        else if (cols_reg == 11'd0)
        begin
            cols_e = POS_W'(1);
        end
        else
        begin
            cols_e = {2'b00, cols_reg};
        end

        if (rows_reg > MAX_ROWS)
        begin
            rows_e = MAX_ROWS;
        end
        else if (rows_reg == 13'd0)
        begin
            rows_e = POS_W'(1);
        end
        else
        begin
            rows_e = rows_reg;
        end

        col_last = cols_e - POS_W'(1);
        row_last = rows_e - POS_W'(1);
        cq       = div3(col_last);
        rq       = div3(row_last);

        lim_next.masks     = (masks_reg > MASKS_SAT) ? MASKS_SAT : masks_reg;
        lim_next.thresh    = thresh_reg;
        lim_next.cols      = cols_e;
        lim_next.rows      = rows_e;
        lim_next.col_last  = col_last;
        lim_next.dx_last   = 2'(col_last - (cq << 1) - cq);
        lim_next.tcol_last = cq;
        lim_next.row_last  = ROW_W'(row_last);
        lim_next.dy_last   = 2'(row_last - (rq << 1) - rq);
        lim_next.trow_last = TROW_W'(rq);
    end

    // the limits settle in the cycle after a write, so pixels are held off in that cycle
    always_ff @(posedge clk)
    begin
        lim_reg <= lim_next;
    end

    assign cfg  = lim_reg;
    assign busy = pend_reg;

endmodule

FILE: hw/rtl/tvm_pos.sv
// raster position counters and per-pixel vote and dark flags
module tvm_pos #(
    parameter int MAX_COLS = 1024
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  tvm_pkg::cfg_t                                        cfg,
    input  logic                                                 accept,
    input  logic                                                 sof,
    input  logic [tvm_pkg::NUM_MASKS-1:0][tvm_pkg::MASK_W-1:0]   masks,
    output tvm_pkg::pix_t                                        pix,
    output logic [$clog2(MAX_COLS)-1:0]                          col
);
    import tvm_pkg::*;

    localparam int CW = $clog2(MAX_COLS);

    logic [CW-1:0]     col_reg, col_next;
    logic [1:0]        dx_reg, dx_next;
    logic [CW-1:0]     tcol_reg, tcol_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [1:0]        dy_reg, dy_next;
    logic [TROW_W-1:0] trow_reg, trow_next;

    logic [CW-1:0]     col_s, col_c, tcol_s, tcol_c;
    logic [1:0]        dx_s, dx_c, dy_s, dy_c;
    logic [ROW_W-1:0]  row_s, row_c;
    logic [TROW_W-1:0] trow_s, trow_c;
    logic [POS_W-1:0]  ti, tj;
    logic              tile_ok;
    logic              vote, dark;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            dx_reg   <= '0;
            tcol_reg <= '0;
            row_reg  <= '0;
            dy_reg   <= '0;
            trow_reg <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            dx_reg   <= dx_next;
            tcol_reg <= tcol_next;
            row_reg  <= row_next;
            dy_reg   <= dy_next;
            trow_reg <= trow_next;
        end
    end

    always_comb
    begin
        col_s  = sof ? '0 : col_reg;
        dx_s   = sof ? '0 : dx_reg;
        tcol_s = sof ? '0 : tcol_reg;
        row_s  = sof ? '0 : row_reg;
        dy_s   = sof ? '0 : dy_reg;
        trow_s = sof ? '0 : trow_reg;

        // a position left beyond the limits by a smaller frame sticks to the last one
        if (POS_W'(col_s) >= cfg.cols)
        begin
            col_c  = CW'(cfg.col_last);
            dx_c   = cfg.dx_last;
            tcol_c = CW'(cfg.tcol_last);
        end
        else
        begin
            col_c  = col_s;
            dx_c   = dx_s;
            tcol_c = tcol_s;
        end
        if (POS_W'(row_s) >= cfg.rows)
        begin
            row_c  = cfg.row_last;
            dy_c   = cfg.dy_last;
            trow_c = cfg.trow_last;
        end
        else
        begin
            row_c  = row_s;
            dy_c   = dy_s;
            trow_c = trow_s;
        end

        vote = 1'b1;
        dark = 1'b0;
        for (int k = 0; k < NUM_MASKS; k++)
        begin
            if (3'(k) < cfg.masks)
            begin
                if (masks[k] > MID_LEVEL)
                begin
                    vote = 1'b0;
                end
                if (masks[k] < MID_LEVEL)
                begin
                    dark = 1'b1;
                end
            end
        end

        ti      = POS_W'(row_c) - POS_W'(dy_c);
        tj      = POS_W'(col_c) - POS_W'(dx_c);
        tile_ok = ({1'b0, ti} + (POS_W+1)'(TILE) < {1'b0, cfg.rows})
               && ({1'b0, tj} + (POS_W+1)'(TILE) < {1'b0, cfg.cols});

        pix.vote     = vote;
        pix.dark     = dark;
        pix.dy       = dy_c;
        pix.tile_end = tile_ok && (dy_c == 2'(TILE - 1)) && (dx_c == 2'(TILE - 1));
        pix.last     = ({1'b0, ti} + (POS_W+1)'(2 * TILE) >= {1'b0, cfg.rows})
                    && ({1'b0, tj} + (POS_W+1)'(2 * TILE) >= {1'b0, cfg.cols});
        pix.trow     = trow_c;
        pix.tcol     = TCOL_W'(tcol_c);

        if (POS_W'(col_c) + POS_W'(1) >= cfg.cols)
        begin
            col_next  = '0;
            dx_next   = '0;
            tcol_next = '0;
            if (POS_W'(row_c) + POS_W'(1) >= cfg.rows)
            begin
                row_next  = '0;
                dy_next   = '0;
                trow_next = '0;
            end
            else
            begin
                row_next = row_c + ROW_W'(1);
                if (dy_c == 2'(TILE - 1))
                begin
                    dy_next   = '0;
                    trow_next = trow_c + TROW_W'(1);
                end
                else
                begin
                    dy_next   = dy_c + 2'd1;
                    trow_next = trow_c;
                end
            end
        end
        else
        begin
            col_next  = col_c + CW'(1);
            row_next  = row_c;
            dy_next   = dy_c;
            trow_next = trow_c;
            if (dx_c == 2'(TILE - 1))
            begin
                dx_next   = '0;
                tcol_next = tcol_c + CW'(1);
            end
            else
            begin
                dx_next   = dx_c + 2'd1;
                tcol_next = tcol_c;
            end
        end
    end

    assign col = col_c;

endmodule

FILE: hw/rtl/tvm_fuse.sv
// line store update, tile vote and black map, result register
module tvm_fuse #(
    parameter int MAX_COLS = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [3:0]                        thresh,
    input  logic                              accept,
    input  tvm_pkg::pix_t                     pix,
    input  logic [$clog2(MAX_COLS)-1:0]       col,
    output logic                              ready,
    input  logic [tvm_pkg::FLAG_W-1:0]        rd_data,
    output logic                              wr_en,
    output logic [$clog2(MAX_COLS)-1:0]       wr_addr,
    output logic [tvm_pkg::FLAG_W-1:0]        wr_data,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tvm_pkg::OUT_W-1:0]         m_tdata,
    output logic                              m_tlast
);
    import tvm_pkg::*;

    localparam int CW = $clog2(MAX_COLS);

    logic              s1_valid_reg;
    pix_t              s1_reg;
    logic [CW-1:0]     s1_col_reg;
    logic              fwd_hit_reg;
    logic [FLAG_W-1:0] fwd_data_reg;
    logic [FLAG_W-1:0] hist0_reg, hist1_reg;
    logic [3:0]        recent_reg;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic              out_last_reg;

    logic              s1_fire;
    logic              out_free;
    logic [FLAG_W-1:0] rd_eff;
    logic [1:0]        flags;
    logic [TILE-1:0][FLAG_W-1:0] col_words;
    logic [TILE-1:0][1:0]        bottom;
    logic [1:0]        f;
    logic [VOTE_W-1:0] votes;
    logic [MAP_W-1:0]  map;

    assign flags    = {s1_reg.dark, s1_reg.vote};
    assign out_free = !out_valid_reg || m_tready;
    assign ready    = !s1_valid_reg || !s1_reg.tile_end || out_free;
    assign s1_fire  = s1_valid_reg && ready;
    assign rd_eff   = fwd_hit_reg ? fwd_data_reg : rd_data;

    // rows above the bottom one merge into the column's store word
    assign wr_en   = s1_fire && (s1_reg.dy != 2'(TILE - 1));
    assign wr_addr = s1_col_reg;
    assign wr_data = (rd_eff & ~(FLAG_W'(2'b11) << (2 * s1_reg.dy)))
                   | (FLAG_W'(flags) << (2 * s1_reg.dy));

    always_comb
    begin
        col_words = {rd_eff, hist0_reg, hist1_reg};
        bottom    = {flags, recent_reg[1:0], recent_reg[3:2]};
        votes     = '0;
        map       = '0;
        for (int c = 0; c < TILE; c++)
        begin
            for (int r = 0; r < TILE; r++)
            begin
                if (r < TILE - 1)
                begin
                    f = col_words[c][2*r +: 2];
                end
                else
                begin
                    f = bottom[c];
                end
                votes = votes + VOTE_W'(f[0]);
                map[TILE*r + c] = f[1];
            end
        end
        if (votes < thresh)
        begin
            map = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            recent_reg    <= '0;
            out_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                // store write at this edge is missed by the read issued at it
                fwd_hit_reg  <= wr_en && (wr_addr == col);
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                recent_reg <= {recent_reg[1:0], flags};
            end

            if (s1_fire && s1_reg.tile_end)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg       <= pix;
            s1_col_reg   <= col;
            fwd_data_reg <= wr_data;
        end
        if (s1_fire)
        begin
            hist1_reg <= hist0_reg;
            hist0_reg <= rd_eff;
        end
        if (s1_fire && s1_reg.tile_end)
        begin
            out_data_reg <= OUT_W'({map, s1_reg.tcol, s1_reg.trow});
            out_last_reg <= s1_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: hw/rtl/tile_vote_mask_merge.sv
// top level of the tile vote mask merge block
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  s_      | in        | s_tvalid / s_tready    | s_tdata masks a..d, s_tuser start of frame
//  m_      | out       | m_tvalid / m_tready    | m_tdata tile row, col, dark map; m_tlast
//  cfg_    | in        | cfg_valid / cfg_ready  | cfg_index register, cfg_data value
//
// one pixel word per clock while s_tready holds; a tile word passes the s1 and output regs
// the line store is read on every pixel; s1 writes back rows above a tile's bottom row
// s_tready drops for the first cycle after reset and after each cfg write
// a tile word waiting in the output register holds pixels only at the next tile end
module tile_vote_mask_merge #(
    parameter int MAX_COLS = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [tvm_pkg::IN_W-1:0]  s_tdata,   // mask_a, mask_b, mask_c, mask_d
    input  logic [0:0]                s_tuser,   // start_of_frame
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [tvm_pkg::OUT_W-1:0] m_tdata,   // tile_row, tile_col, dark_bits, zero fill
    output logic                      m_tlast,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [tvm_pkg::CFG_W-1:0] cfg_data
);
    import tvm_pkg::*;

    localparam int CW = $clog2(MAX_COLS);

    cfg_t                              cfg;
    logic                              busy;
    logic                              accept;
    logic                              fuse_ready;
    pix_t                              pix;
    logic [CW-1:0]                     col;
    logic [NUM_MASKS-1:0][MASK_W-1:0]  masks;
    logic                              wr_en;
    logic [CW-1:0]                     wr_addr;
    logic [FLAG_W-1:0]                 wr_data;
    logic [FLAG_W-1:0]                 rd_data;

    assign masks    = s_tdata;
    assign s_tready = fuse_ready && !busy;
    assign accept   = s_tvalid && s_tready;

    tvm_cfg #(
        .MAX_COLS (MAX_COLS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .busy      (busy)
    );

    tvm_pos #(
        .MAX_COLS (MAX_COLS)
    ) u_pos (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .accept (accept),
        .sof    (s_tuser[0]),
        .masks  (masks),
        .pix    (pix),
        .col    (col)
    );

    tvm_ram #(
        .WIDTH (FLAG_W),
        .DEPTH (MAX_COLS)
    ) u_line (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (col),
        .rd_data (rd_data)
    );

    tvm_fuse #(
        .MAX_COLS (MAX_COLS)
    ) u_fuse (
        .clk      (clk),
        .rst_n    (rst_n),
        .thresh   (cfg.thresh),
        .accept   (accept),
        .pix      (pix),
        .col      (col),
        .ready    (fuse_ready),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
